// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion helpers for the rtl folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("property failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== rtl/amm_pkg.sv =====
// ----------------------------------------------------------------------------
// amm_pkg
// Types and constants of the anisotropic mass motion derivative block.
// ----------------------------------------------------------------------------
package amm_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_REGS      = 7;
    localparam int ADDR_W        = 5;
    localparam int ISQ_STEPS     = 32;
    localparam int QUO_BITS      = 33;
    localparam int NUM_DIV       = 7;
    localparam int IN_W          = 192;
    localparam int OUT_W         = 224;

    typedef enum logic [2:0] {
        REG_INV_MASS_XX = 3'd0,
        REG_INV_MASS_XY = 3'd1,
        REG_INV_MASS_XZ = 3'd2,
        REG_INV_MASS_YY = 3'd3,
        REG_INV_MASS_YZ = 3'd4,
        REG_INV_MASS_ZZ = 3'd5,
        REG_FORCE_SCALE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]        vneg;
        logic [2:0][31:0]  vmag;
        logic [2:0]        fneg;
        logic [2:0][62:0]  fmag;
    } carry_t;

    typedef struct packed {
        logic [35:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } isq_t;

    typedef struct packed {
        logic [63:0]         rem;
        logic [QUO_BITS-1:0] quo;
        logic                ovf;
    } div_t;

endpackage

// ===== rtl/anisotropic_mass_motion_derivative.sv =====
// ----------------------------------------------------------------------------
// anisotropic_mass_motion_derivative
// Velocity from momentum through a symmetric inverse-mass tensor, then unit
// direction, field-driven momentum change per path length and 1/|v|.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one transaction carries momentum and field (6 x 32 bits).
//   m_ channel: one transaction per input with direction, momentum change,
//   inverse speed in m_tdata and the zero speed flag in m_tuser.
//   apb port: seven 32-bit registers at byte addresses 0,4,..,24. Write them
//   only while no transaction is in flight; the block does not enforce it.
//   pipeline: 4 arithmetic stages, 32 square root stages at one root bit
//   each, 33 divider stages at one quotient bit each, 1 output register.
//   throughput: one transaction per cycle unless the output stalls;
//   the square root and the seven bit-per-stage dividers are fully pipelined.
//   reset: aresetn low clears the valid bits and config registers to 0
//   and empties the pipeline; the payload registers are not reset.
//   stall: when m_tready is low with a result pending, the whole pipeline
//   holds and s_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module anisotropic_mass_motion_derivative #(
    parameter int FRAC_BITS = amm_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // mom_x, mom_y, mom_z, efield_x, efield_y, efield_z
    input  logic [amm_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // dir_x, dir_y, dir_z, dmom_x, dmom_y, dmom_z, inv_speed, 1 zero pad bit
    output logic [amm_pkg::OUT_W-1:0]   m_tdata,
    // zero_speed
    output logic                        m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [amm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int ISQ_N = amm_pkg::ISQ_STEPS;
    localparam int DIV_N = amm_pkg::QUO_BITS;
    localparam int ND    = amm_pkg::NUM_DIV;
    localparam logic signed [31:0] DIR_ONE = 32'(1) << FRAC_BITS;

    function automatic logic signed [31:0] sat32(logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic amm_pkg::isq_t isq_step(amm_pkg::isq_t a);
        logic [37:0] rem2;
        logic [37:0] tval;
        amm_pkg::isq_t r;
        rem2  = {a.rem, a.rad[63:62]};
        tval  = {4'b0, a.root, 2'b01};
        r.rad = {a.rad[61:0], 2'b00};
        if (rem2 >= tval) begin
            r.rem  = 36'(rem2 - tval);
            r.root = {a.root[30:0], 1'b1};
        end else begin
            r.rem  = rem2[35:0];
            r.root = {a.root[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic amm_pkg::div_t div_step(amm_pkg::div_t a, logic [31:0] den, int k);
        logic [65:0] trial;
        amm_pkg::div_t r;
        r     = a;
        trial = {2'b00, a.rem} - (66'(den) << k);
        if (!trial[65]) begin
            r.rem    = trial[63:0];
            r.quo[k] = 1'b1;
        end
        return r;
    endfunction

    // configuration registers
    logic [31:0] cfg_reg [amm_pkg::NUM_REGS];
    logic [2:0]  cfg_idx;

    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign prdata  = (cfg_idx < 3'(amm_pkg::NUM_REGS)) ? cfg_reg[cfg_idx] : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < amm_pkg::NUM_REGS; i++) begin
                cfg_reg[i] <= 32'd0;
            end
        end else if (psel && penable && pwrite && pready
                     && (cfg_idx < 3'(amm_pkg::NUM_REGS))) begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    // pipeline control
    logic en;
    logic m_tvalid_reg;
    logic [amm_pkg::OUT_W-1:0] m_tdata_reg;
    logic m_tuser_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // stage 1: tensor and field products
    logic signed [31:0] mat [3][3];
    logic signed [31:0] pin [3];
    logic signed [31:0] ein [3];
    logic signed [63:0] s1_prod_next [3][3];
    logic signed [63:0] s1_prod_reg  [3][3];
    logic signed [63:0] s1_fe_next [3];
    logic signed [63:0] s1_fe_reg  [3];
    logic s1_valid_reg;

    always_comb begin
        mat[0][0] = cfg_reg[amm_pkg::REG_INV_MASS_XX];
        mat[0][1] = cfg_reg[amm_pkg::REG_INV_MASS_XY];
        mat[0][2] = cfg_reg[amm_pkg::REG_INV_MASS_XZ];
        mat[1][0] = cfg_reg[amm_pkg::REG_INV_MASS_XY];
        mat[1][1] = cfg_reg[amm_pkg::REG_INV_MASS_YY];
        mat[1][2] = cfg_reg[amm_pkg::REG_INV_MASS_YZ];
        mat[2][0] = cfg_reg[amm_pkg::REG_INV_MASS_XZ];
        mat[2][1] = cfg_reg[amm_pkg::REG_INV_MASS_YZ];
        mat[2][2] = cfg_reg[amm_pkg::REG_INV_MASS_ZZ];
        for (int i = 0; i < 3; i++) begin
            pin[i] = s_tdata[32*i +: 32];
            ein[i] = s_tdata[96 + 32*i +: 32];
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s1_prod_next[i][j] = mat[i][j] * pin[j];
            end
            s1_fe_next[i] = $signed(cfg_reg[amm_pkg::REG_FORCE_SCALE]) * ein[i];
        end
    end

    // stage 2: floor shift, sum, saturate; field magnitudes
    logic signed [65:0] acc [3];
    logic signed [31:0] s2_v_next [3];
    logic signed [31:0] s2_v_reg  [3];
    logic [2:0]         s2_fneg_next, s2_fneg_reg;
    logic [62:0]        s2_fmag_next [3];
    logic [62:0]        s2_fmag_reg  [3];
    logic s2_valid_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = 66'(s1_prod_reg[i][0] >>> FRAC_BITS)
                   + 66'(s1_prod_reg[i][1] >>> FRAC_BITS)
                   + 66'(s1_prod_reg[i][2] >>> FRAC_BITS);
            s2_v_next[i]    = sat32(acc[i]);
            s2_fneg_next[i] = s1_fe_reg[i][63];
            s2_fmag_next[i] = s1_fe_reg[i][63] ? 63'(-s1_fe_reg[i]) : s1_fe_reg[i][62:0];
        end
    end

    // stage 3: velocity magnitudes and squares
    amm_pkg::carry_t s3_carry_next, s3_carry_reg;
    logic [63:0] s3_sq_next [3];
    logic [63:0] s3_sq_reg  [3];
    logic s3_valid_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s3_carry_next.vneg[i] = s2_v_reg[i][31];
            s3_carry_next.vmag[i] = s2_v_reg[i][31] ? 32'(-s2_v_reg[i]) : 32'(s2_v_reg[i]);
            s3_carry_next.fneg[i] = s2_fneg_reg[i];
            s3_carry_next.fmag[i] = s2_fmag_reg[i];
            s3_sq_next[i] = s3_carry_next.vmag[i] * s3_carry_next.vmag[i];
        end
    end

    // stage 4: sum of squares
    amm_pkg::carry_t s4_carry_reg;
    logic [63:0] s4_sum_reg;
    logic s4_valid_reg;

    // square root pipeline
    amm_pkg::isq_t   isq_init;
    amm_pkg::isq_t   isq_next  [ISQ_N];
    amm_pkg::isq_t   isq_reg   [ISQ_N];
    amm_pkg::carry_t isq_carry_reg [ISQ_N];
    logic [ISQ_N-1:0] isq_valid_reg;

    always_comb begin
        isq_init.rem  = 36'd0;
        isq_init.root = 32'd0;
        isq_init.rad  = s4_sum_reg;
        isq_next[0]   = isq_step(isq_init);
        for (int s = 1; s < ISQ_N; s++) begin
            isq_next[s] = isq_step(isq_reg[s-1]);
        end
    end

    // divider pipeline
    amm_pkg::carry_t cl;
    logic [31:0]   div_den_in;
    logic [63:0]   num_in [ND];
    amm_pkg::div_t div_init [ND];
    logic [ND-1:0] neg_in;
    amm_pkg::div_t div_next [DIV_N][ND];
    amm_pkg::div_t div_reg  [DIV_N][ND];
    logic [31:0]   div_den_reg [DIV_N];
    logic [ND-1:0] div_neg_reg [DIV_N];
    logic [DIV_N-1:0] div_valid_reg;

    always_comb begin
        cl         = isq_carry_reg[ISQ_N-1];
        div_den_in = isq_reg[ISQ_N-1].root;
        for (int l = 0; l < 3; l++) begin
            num_in[l]   = 64'(cl.vmag[l]) << FRAC_BITS;
            num_in[3+l] = 64'(cl.fmag[l]);
            neg_in[l]   = cl.vneg[l];
            neg_in[3+l] = cl.fneg[l];
        end
        num_in[6] = 64'(1) << (2 * FRAC_BITS);
        neg_in[6] = 1'b0;
        for (int l = 0; l < ND; l++) begin
            div_init[l].rem = num_in[l];
            div_init[l].quo = '0;
            div_init[l].ovf = (num_in[l] >> DIV_N) >= 64'(div_den_in);
            div_next[0][l]  = div_step(div_init[l], div_den_in, DIV_N - 1);
        end
        for (int s = 1; s < DIV_N; s++) begin
            for (int l = 0; l < ND; l++) begin
                div_next[s][l] = div_step(div_reg[s-1][l], div_den_reg[s-1], DIV_N - 1 - s);
            end
        end
    end

    // output formatting
    amm_pkg::div_t   fl;
    logic [DIV_N-1:0] qm;
    logic [31:0]     res [6];
    logic [30:0]     inv_res;
    logic            zero_out;
    logic [amm_pkg::OUT_W-1:0] m_tdata_next;

    always_comb begin
        zero_out = div_den_reg[DIV_N-1] == 32'd0;
        for (int l = 0; l < 6; l++) begin
            fl = div_reg[DIV_N-1][l];
            qm = (fl.ovf || fl.quo > 33'h080000000) ? 33'h080000000 : fl.quo;
            if (div_neg_reg[DIV_N-1][l]) begin
                res[l] = 32'(-qm);
            end else if (qm >= 33'h080000000) begin
                res[l] = 32'h7FFFFFFF;
            end else begin
                res[l] = qm[31:0];
            end
        end
        fl = div_reg[DIV_N-1][6];
        qm = fl.quo;
        inv_res = (fl.ovf || fl.quo >= 33'h080000000) ? 31'h7FFFFFFF : qm[30:0];
        if (zero_out) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {1'b0, inv_res, res[5], res[4], res[3], res[2], res[1], res[0]};
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            isq_valid_reg <= '0;
            div_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= s_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            isq_valid_reg <= {isq_valid_reg[ISQ_N-2:0], s4_valid_reg};
            div_valid_reg <= {div_valid_reg[DIV_N-2:0], isq_valid_reg[ISQ_N-1]};
            m_tvalid_reg  <= div_valid_reg[DIV_N-1];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prod_reg  <= s1_prod_next;
            s1_fe_reg    <= s1_fe_next;
            s2_v_reg     <= s2_v_next;
            s2_fneg_reg  <= s2_fneg_next;
            s2_fmag_reg  <= s2_fmag_next;
            s3_carry_reg <= s3_carry_next;
            s3_sq_reg    <= s3_sq_next;
            s4_carry_reg <= s3_carry_reg;
            s4_sum_reg   <= s3_sq_reg[0] + s3_sq_reg[1] + s3_sq_reg[2];
            isq_carry_reg[0] <= s4_carry_reg;
            for (int s = 0; s < ISQ_N; s++) begin
                isq_reg[s] <= isq_next[s];
            end
            for (int s = 1; s < ISQ_N; s++) begin
                isq_carry_reg[s] <= isq_carry_reg[s-1];
            end
            div_den_reg[0] <= div_den_in;
            div_neg_reg[0] <= neg_in;
            for (int s = 0; s < DIV_N; s++) begin
                div_reg[s] <= div_next[s];
            end
            for (int s = 1; s < DIV_N; s++) begin
                div_den_reg[s] <= div_den_reg[s-1];
                div_neg_reg[s] <= div_neg_reg[s-1];
            end
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= zero_out;
        end
    end

    // checks
    `ASSERT_PROP(a_zero_clears_data, aclk, aresetn,
        (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg == '0))
    `ASSERT_PROP(a_dir_bounded, aclk, aresetn,
        (m_tvalid_reg && !m_tuser_reg) |->
            ($signed(m_tdata_reg[31:0]) <= DIR_ONE && $signed(m_tdata_reg[31:0]) >= -DIR_ONE))
    `ASSERT_PROP(a_isq_to_div, aclk, aresetn,
        (isq_valid_reg[ISQ_N-1] && en) |=> div_valid_reg[0])

endmodule
